// File: rtl/core/assert_macros.svh
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/v3a_pkg.sv
`default_nettype none
package v3a_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int ProdW    = 2 * DataW;
  localparam int AccW     = ProdW + 2;
  localparam int SqW      = ProdW;
  localparam int RootW    = SqW / 2;
  localparam int NumW     = DataW + FracBits;
  localparam int QuoW     = FracBits + 1;
  localparam int RemW     = RootW + 1;

  typedef enum logic [2:0] {
    CmdAdd   = 3'd0,
    CmdSub   = 3'd1,
    CmdScale = 3'd2,
    CmdDot   = 3'd3,
    CmdCross = 3'd4,
    CmdLen   = 3'd5,
    CmdNorm  = 3'd6
  } cmd_e;

  typedef logic [DataW-1:0] word_t;

  localparam word_t WordMax = {1'b0, {(DataW-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(DataW-1){1'b0}}};

  // Products and plain sums after the multiplier stage
  typedef struct packed {
    logic [2:0]              cmd;
    word_t [2:0]             a;
    logic [2:0][DataW:0]     addsub;
    logic [5:0][ProdW-1:0]   prod;
  } mul_t;

  // Finished linear results plus the sum of squares
  typedef struct packed {
    logic [2:0]      cmd;
    word_t [2:0]     a;
    word_t [2:0]     r;
    word_t           sc;
    logic            ov;
    logic [SqW-1:0]  sq;
  } comb_t;

  // After the square root
  typedef struct packed {
    logic [2:0]        cmd;
    word_t [2:0]       a;
    word_t [2:0]       r;
    word_t             sc;
    logic              ov;
    logic [RootW-1:0]  root;
  } rt_t;

  // Result beat
  typedef struct packed {
    word_t [2:0] r;
    word_t       sc;
    logic        ov;
  } res_t;

  typedef struct packed {
    word_t val;
    logic  ov;
  } sat_t;

  // Clamp a wide signed value to the word range
  function automatic sat_t sat_acc(input logic signed [AccW-1:0] x);
    sat_t s;
    s.val = x[DataW-1:0];
    s.ov  = 1'b0;
    if (x[AccW-1:DataW-1] != {(AccW-DataW+1){x[AccW-1]}}) begin
      s.ov  = 1'b1;
      s.val = x[AccW-1] ? WordMin : WordMax;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/vector3_arith_unit.sv
// Stages in order: multiply, sum, clamp, square root, divide, output register.
// Throughput: one item per cycle when the output is not stalled; depth is set
// by the 32-stage square root and the 17-stage three-lane divider.
// Stalls back up stage by stage.
// Reset (rst_ni low, asynchronous) empties every stage; the data registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module vector3_arith_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               cmd_i,
  input  logic signed [31:0]       ax_i,
  input  logic signed [31:0]       ay_i,
  input  logic signed [31:0]       az_i,
  input  logic signed [31:0]       bx_i,
  input  logic signed [31:0]       by_comp_i,
  input  logic signed [31:0]       bz_i,
  input  logic signed [31:0]       factor_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [31:0]       rx_o,
  output logic signed [31:0]       ry_o,
  output logic signed [31:0]       rz_o,
  output logic signed [31:0]       scalar_out_o,
  output logic                     overflow_o
);
  import v3a_pkg::*;

  word_t [2:0] a_vec, b_vec;
  mul_t        mul_data;
  comb_t       comb_data;
  rt_t         rt_data;
  res_t        res;
  logic        mul_valid, mul_ready;
  logic        comb_valid, comb_ready;
  logic        rt_valid, rt_ready;
  logic        out_held;
  logic        any_rail;
  logic        ov_beat;

  assign a_vec = {az_i, ay_i, ax_i};
  assign b_vec = {bz_i, by_comp_i, bx_i};

  v3a_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .a_i         (a_vec),
    .b_i         (b_vec),
    .f_i         (factor_i),
    .out_valid_o (mul_valid),
    .out_ready_i (mul_ready),
    .out_o       (mul_data)
  );

  v3a_comb u_comb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_valid),
    .in_ready_o  (mul_ready),
    .in_i        (mul_data),
    .out_valid_o (comb_valid),
    .out_ready_i (comb_ready),
    .out_o       (comb_data)
  );

  v3a_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (comb_valid),
    .in_ready_o  (comb_ready),
    .in_i        (comb_data),
    .out_valid_o (rt_valid),
    .out_ready_i (rt_ready),
    .out_o       (rt_data)
  );

  v3a_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rt_valid),
    .in_ready_o  (rt_ready),
    .in_i        (rt_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign rx_o         = res.r[0];
  assign ry_o         = res.r[1];
  assign rz_o         = res.r[2];
  assign scalar_out_o = res.sc;
  assign overflow_o   = res.ov;

  // Conditions watched by the checks below
  assign out_held = out_valid_o && !out_ready_i;
  assign ov_beat  = out_valid_o && overflow_o;
  assign any_rail = (rx_o == WordMax) || (rx_o == WordMin)
                 || (ry_o == WordMax) || (ry_o == WordMin)
                 || (rz_o == WordMax) || (rz_o == WordMin)
                 || (scalar_out_o == WordMax) || (scalar_out_o == WordMin);

  // Input back-pressure only when every stage is full and the output is held
  `ASSERT_IMPLIES(a_full_stall, clk_i, rst_ni, !in_ready_o, out_held, "input stalled while pipeline can drain")

  // A saturated beat carries at least one field on a rail
  `ASSERT_IMPLIES(a_ov_rail, clk_i, rst_ni, ov_beat, any_rail, "overflow flag without a saturated field")

endmodule
`default_nettype wire

// File: rtl/core/v3a_mul.sv
`default_nettype none
module v3a_mul (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              cmd_i,
  input  v3a_pkg::word_t [2:0]    a_i,
  input  v3a_pkg::word_t [2:0]    b_i,
  input  v3a_pkg::word_t          f_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output v3a_pkg::mul_t           out_o
);
  import v3a_pkg::*;

  word_t [5:0]             opa;
  word_t [5:0]             opb;
  logic signed [ProdW-1:0] pr [6];
  mul_t                    d;
  mul_t                    data_q;
  logic                    valid_q;
  logic                    adv;

  // Route operands to the six multipliers
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd_i)
      CmdScale: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = a_i[i];
          opb[i] = f_i;
        end
      end
      CmdDot: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = a_i[i];
          opb[i] = b_i[i];
        end
      end
      CmdCross: begin
        opa[0] = a_i[1]; opb[0] = b_i[2];
        opa[1] = a_i[2]; opb[1] = b_i[1];
        opa[2] = a_i[2]; opb[2] = b_i[0];
        opa[3] = a_i[0]; opb[3] = b_i[2];
        opa[4] = a_i[0]; opb[4] = b_i[1];
        opa[5] = a_i[1]; opb[5] = b_i[0];
      end
      CmdLen, CmdNorm: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = a_i[i];
          opb[i] = a_i[i];
        end
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Multiply and form the plain sums
  always_comb begin
    d.cmd = cmd_i;
    d.a   = a_i;
    for (int k = 0; k < 6; k++) begin
      pr[k]     = $signed(opa[k]) * $signed(opb[k]);
      d.prod[k] = pr[k];
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd_i == CmdSub) begin
        d.addsub[i] = {a_i[i][DataW-1], a_i[i]} - {b_i[i][DataW-1], b_i[i]};
      end else begin
        d.addsub[i] = {a_i[i][DataW-1], a_i[i]} + {b_i[i][DataW-1], b_i[i]};
      end
    end
  end

  assign adv        = !valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      data_q <= d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule
`default_nettype wire

// File: rtl/core/v3a_comb.sv
`default_nettype none
module v3a_comb (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  v3a_pkg::mul_t    in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output v3a_pkg::comb_t   out_o
);
  import v3a_pkg::*;

  typedef struct packed {
    logic [2:0]             cmd;
    word_t [2:0]            a;
    logic [2:0][DataW:0]    addsub;
    logic [2:0][AccW-1:0]   w;
  } sum_t;

  sum_t  sum_d, sum_q;
  comb_t fin_d, fin_q;
  logic  v0_q, v1_q;
  logic  rdy0, rdy1;

  // Combine the products into sums or differences
  always_comb begin
    sum_d.cmd    = in_i.cmd;
    sum_d.a      = in_i.a;
    sum_d.addsub = in_i.addsub;
    sum_d.w      = '0;
    case (in_i.cmd)
      CmdScale: begin
        for (int i = 0; i < 3; i++) begin
          sum_d.w[i] = AccW'($signed(in_i.prod[i]));
        end
      end
      CmdDot, CmdLen, CmdNorm: begin
        sum_d.w[0] = AccW'($signed(in_i.prod[0])) + AccW'($signed(in_i.prod[1]))
                   + AccW'($signed(in_i.prod[2]));
      end
      CmdCross: begin
        for (int i = 0; i < 3; i++) begin
          sum_d.w[i] = AccW'($signed(in_i.prod[2*i])) - AccW'($signed(in_i.prod[2*i+1]));
        end
      end
      default: sum_d.w = '0;
    endcase
  end

  // Drop the fraction bits and clamp; add and subtract are only clamped
  always_comb begin
    logic signed [AccW-1:0] sh [3];
    sat_t                   s  [3];
    fin_d.cmd = sum_q.cmd;
    fin_d.a   = sum_q.a;
    fin_d.r   = '0;
    fin_d.sc  = '0;
    fin_d.ov  = 1'b0;
    fin_d.sq  = sum_q.w[0][SqW-1:0];
    for (int i = 0; i < 3; i++) begin
      sh[i] = $signed(sum_q.w[i]) >>> FracBits;
      s[i]  = sat_acc(sh[i]);
    end
    case (sum_q.cmd)
      CmdAdd, CmdSub: begin
        for (int i = 0; i < 3; i++) begin
          s[i]       = sat_acc(AccW'($signed(sum_q.addsub[i])));
          fin_d.r[i] = s[i].val;
        end
        fin_d.ov = s[0].ov | s[1].ov | s[2].ov;
      end
      CmdScale, CmdCross: begin
        for (int i = 0; i < 3; i++) begin
          fin_d.r[i] = s[i].val;
        end
        fin_d.ov = s[0].ov | s[1].ov | s[2].ov;
      end
      CmdDot: begin
        fin_d.sc = s[0].val;
        fin_d.ov = s[0].ov;
      end
      default: fin_d.ov = 1'b0;
    endcase
  end

  assign rdy1       = !v1_q || out_ready_i;
  assign rdy0       = !v0_q || rdy1;
  assign in_ready_o = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) sum_q <= sum_d;
    if (rdy1) fin_q <= fin_d;
  end

  assign out_valid_o = v1_q;
  assign out_o       = fin_q;

endmodule
`default_nettype wire

// File: rtl/core/v3a_sqrt.sv
`default_nettype none
module v3a_sqrt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  v3a_pkg::comb_t   in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output v3a_pkg::rt_t     out_o
);
  import v3a_pkg::*;

  localparam int NStg = RootW;

  typedef struct packed {
    logic [2:0]      cmd;
    word_t [2:0]     a;
    word_t [2:0]     r;
    word_t           sc;
    logic            ov;
    logic [SqW-1:0]  n;
    logic [SqW-1:0]  res;
  } sq_t;

  sq_t             init;
  sq_t             stg_in [NStg];
  sq_t             nxt  [NStg];
  sq_t             d_q  [NStg];
  logic [NStg-1:0] v_in;
  logic [NStg-1:0] v_q;
  logic [NStg:0]   rdy;

  always_comb begin
    init.cmd = in_i.cmd;
    init.a   = in_i.a;
    init.r   = in_i.r;
    init.sc  = in_i.sc;
    init.ov  = in_i.ov;
    init.n   = in_i.sq;
    init.res = '0;
  end

  // Feed each stage from the one before it
  always_comb begin
    stg_in[0] = init;
    for (int k = 1; k < NStg; k++) begin
      stg_in[k] = d_q[k-1];
    end
  end

  assign v_in = {v_q[NStg-2:0], in_valid_i};

  // One result bit per stage, highest first
  always_comb begin
    sq_t            src;
    logic [SqW-1:0] bitv;
    logic [SqW-1:0] trial;
    for (int k = 0; k < NStg; k++) begin
      src   = stg_in[k];
      bitv  = {{(SqW-1){1'b0}}, 1'b1} << (SqW - 2 - 2*k);
      trial = src.res + bitv;
      nxt[k] = src;
      if (src.n >= trial) begin
        nxt[k].n   = src.n - trial;
        nxt[k].res = (src.res >> 1) + bitv;
      end else begin
        nxt[k].res = src.res >> 1;
      end
    end
  end

  // Stall chain: a stage takes a beat when empty or draining
  always_comb begin
    rdy[NStg] = out_ready_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (rdy[k]) v_q[k] <= v_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NStg; k++) begin
      if (rdy[k]) d_q[k] <= nxt[k];
    end
  end

  assign out_valid_o = v_q[NStg-1];
  assign out_o.cmd   = d_q[NStg-1].cmd;
  assign out_o.a     = d_q[NStg-1].a;
  assign out_o.r     = d_q[NStg-1].r;
  assign out_o.sc    = d_q[NStg-1].sc;
  assign out_o.ov    = d_q[NStg-1].ov;
  assign out_o.root  = d_q[NStg-1].res[RootW-1:0];

endmodule
`default_nettype wire

// File: rtl/core/v3a_div.sv
`default_nettype none
module v3a_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  v3a_pkg::rt_t    in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output v3a_pkg::res_t   out_o
);
  import v3a_pkg::*;

  localparam int NStg = QuoW;

  typedef struct packed {
    logic [2:0]            cmd;
    logic [2:0]            neg;
    word_t [2:0]           r;
    word_t                 sc;
    logic                  ov;
    logic [RootW-1:0]      root;
    logic [2:0][RemW-1:0]  rem;
    logic [2:0][NumW-1:0]  num;
    logic [2:0][QuoW-1:0]  q;
  } dv_t;

  dv_t             init;
  dv_t             stg_in [NStg];
  dv_t             nxt [NStg];
  dv_t             d_q [NStg];
  logic [NStg-1:0] v_in;
  logic [NStg-1:0] v_q;
  logic [NStg:0]   rdy;
  res_t            fin_d, res_q;
  logic            fin_v_q;
  logic            fin_rdy;

  // Load magnitudes shifted up by the fraction width
  always_comb begin
    word_t mg;
    init.cmd  = in_i.cmd;
    init.r    = in_i.r;
    init.sc   = in_i.sc;
    init.ov   = in_i.ov;
    init.root = in_i.root;
    init.q    = '0;
    for (int l = 0; l < 3; l++) begin
      init.neg[l] = in_i.a[l][DataW-1];
      mg          = in_i.a[l][DataW-1] ? (~in_i.a[l] + 1'b1) : in_i.a[l];
      init.num[l] = {mg, {FracBits{1'b0}}};
      init.rem[l] = RemW'(init.num[l][NumW-1:QuoW]);
    end
  end

  // Feed each stage from the one before it
  always_comb begin
    stg_in[0] = init;
    for (int k = 1; k < NStg; k++) begin
      stg_in[k] = d_q[k-1];
    end
  end

  assign v_in = {v_q[NStg-2:0], in_valid_i};

  // One quotient bit per stage in each of three lanes
  always_comb begin
    dv_t             src;
    logic [RemW-1:0] rem2;
    for (int k = 0; k < NStg; k++) begin
      src    = stg_in[k];
      nxt[k] = src;
      for (int l = 0; l < 3; l++) begin
        rem2 = {src.rem[l][RemW-2:0], src.num[l][NStg-1-k]};
        if (rem2 >= {1'b0, src.root}) begin
          nxt[k].rem[l]          = rem2 - {1'b0, src.root};
          nxt[k].q[l][NStg-1-k]  = 1'b1;
        end else begin
          nxt[k].rem[l] = rem2;
        end
      end
    end
  end

  // Assemble the result beat
  always_comb begin
    dv_t   last;
    word_t qw;
    last     = d_q[NStg-1];
    fin_d.r  = last.r;
    fin_d.sc = last.sc;
    fin_d.ov = last.ov;
    case (last.cmd)
      CmdLen: begin
        fin_d.r  = '0;
        fin_d.ov = last.root[RootW-1];
        fin_d.sc = last.root[RootW-1] ? WordMax : last.root[DataW-1:0];
      end
      CmdNorm: begin
        fin_d.sc = '0;
        fin_d.ov = 1'b0;
        for (int l = 0; l < 3; l++) begin
          qw         = DataW'(last.q[l]);
          fin_d.r[l] = (last.root == '0) ? '0 : (last.neg[l] ? (~qw + 1'b1) : qw);
        end
      end
      default: fin_d.ov = last.ov;
    endcase
  end

  always_comb begin
    fin_rdy    = !fin_v_q || out_ready_i;
    rdy[NStg]  = fin_rdy;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      fin_v_q <= 1'b0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (rdy[k]) v_q[k] <= v_in[k];
      end
      if (fin_rdy) fin_v_q <= v_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NStg; k++) begin
      if (rdy[k]) d_q[k] <= nxt[k];
    end
    if (fin_rdy) res_q <= fin_d;
  end

  assign out_valid_o = fin_v_q;
  assign out_o       = res_q;

endmodule
`default_nettype wire

// File: verif/vector3_arith_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none
module vector3_arith_unit_test;
  import v3a_pkg::*;

  localparam logic [2:0] CmdUnknown = 3'd7;
  localparam int unsigned RandItems = 950;

  typedef logic signed [31:0] sword_t;
  typedef logic signed [71:0] wide_t;

  typedef struct {
    logic [2:0] cmd;
    sword_t     a [3];
    sword_t     b [3];
    sword_t     factor;
  } vec_item_t;

  typedef struct {
    logic [31:0] r [3];
    logic [31:0] sc;
    logic        ov;
  } vec_result_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  logic [2:0] cmd;
  sword_t ax, ay, az, bx, by_c, bz, factor;
  logic   out_valid;
  logic   out_ready;
  sword_t rx, ry, rz, sc_out;
  logic   ov_out;

  vec_result_t expected_results [$];
  int unsigned err_count;
  int unsigned cycle_cnt;

  vector3_arith_unit i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_i        (cmd),
    .ax_i         (ax),
    .ay_i         (ay),
    .az_i         (az),
    .bx_i         (bx),
    .by_comp_i    (by_c),
    .bz_i         (bz),
    .factor_i     (factor),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .rx_o         (rx),
    .ry_o         (ry),
    .rz_o         (rz),
    .scalar_out_o (sc_out),
    .overflow_o   (ov_out)
  );

  // Free-running clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Clamp to the word range, flag any saturation
  function automatic logic [31:0] clamp_word(input wide_t x, inout logic ov);
    if (x > wide_t'(32'sh7fffffff)) begin
      ov = 1'b1;
      return WordMax;
    end
    if (x < wide_t'(-72'sd2147483648)) begin
      ov = 1'b1;
      return WordMin;
    end
    return x[31:0];
  endfunction

  // Floor square root, one bit per step from the top
  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Work out the result beat that one item must produce
  function automatic vec_result_t predict_vec(input vec_item_t it);
    vec_result_t res;
    wide_t       wa [3];
    wide_t       wb [3];
    wide_t       wf;
    wide_t       sum;
    logic [63:0] sq;
    logic [63:0] mg;
    logic [63:0] root;
    int          j, k;
    res.r[0] = '0;
    res.r[1] = '0;
    res.r[2] = '0;
    res.sc = '0;
    res.ov = 1'b0;
    for (int i = 0; i < 3; i++) begin
      wa[i] = it.a[i];
      wb[i] = it.b[i];
    end
    wf = it.factor;
    case (it.cmd)
      CmdAdd: for (int i = 0; i < 3; i++) res.r[i] = clamp_word(wa[i] + wb[i], res.ov);
      CmdSub: for (int i = 0; i < 3; i++) res.r[i] = clamp_word(wa[i] - wb[i], res.ov);
      CmdScale: begin
        for (int i = 0; i < 3; i++) res.r[i] = clamp_word((wa[i] * wf) >>> 16, res.ov);
      end
      CmdDot: begin
        sum = wa[0] * wb[0] + wa[1] * wb[1] + wa[2] * wb[2];
        res.sc = clamp_word(sum >>> 16, res.ov);
      end
      CmdCross: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          res.r[i] = clamp_word((wa[j] * wb[k] - wa[k] * wb[j]) >>> 16, res.ov);
        end
      end
      CmdLen, CmdNorm: begin
        // sum of squares wraps at 64 bits, as the hardware does
        sq = '0;
        for (int i = 0; i < 3; i++) begin
          mg = wa[i] < 0 ? 64'(-wa[i]) : 64'(wa[i]);
          sq = sq + mg * mg;
        end
        root = floor_root(sq);
        if (it.cmd == CmdLen) begin
          res.sc = clamp_word(wide_t'({8'd0, root}), res.ov);
        end else if (root != 0) begin
          for (int i = 0; i < 3; i++) begin
            res.r[i] = clamp_word((wa[i] <<< 16) / $signed({8'd0, root}), res.ov);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  // Drive one beat, hold it until taken, then leave a gap of idle cycles
  task automatic send_vec(input vec_item_t it, input int unsigned gap);
    logic ready_now;
    in_valid <= 1'b1;
    cmd      <= it.cmd;
    ax       <= it.a[0];
    ay       <= it.a[1];
    az       <= it.a[2];
    bx       <= it.b[0];
    by_c     <= it.b[1];
    bz       <= it.b[2];
    factor   <= it.factor;
    forever begin
      @(negedge clk);
      ready_now = in_ready;
      @(posedge clk);
      if (ready_now) break;
    end
    expected_results.push_back(predict_vec(it));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic vec_item_t make_vec(input logic [2:0] c, input sword_t x0, input sword_t y0,
                                         input sword_t z0, input sword_t x1, input sword_t y1,
                                         input sword_t z1, input sword_t f);
    vec_item_t it;
    it.cmd = c;
    it.a[0] = x0;
    it.a[1] = y0;
    it.a[2] = z0;
    it.b[0] = x1;
    it.b[1] = y1;
    it.b[2] = z1;
    it.factor = f;
    return it;
  endfunction

  // Mix of extremes, small magnitudes and full-range words
  function automatic sword_t rand_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return WordMax;
          1: return WordMin;
          2: return 32'sd0;
          3: return 32'sd65536;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3, 4: return sword_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return sword_t'($urandom);
    endcase
  endfunction

  function automatic vec_item_t rand_vec();
    vec_item_t it;
    // mostly valid commands, the odd unknown one
    it.cmd = ($urandom_range(0, 19) == 0) ? CmdUnknown : 3'($urandom_range(0, 6));
    for (int i = 0; i < 3; i++) begin
      it.a[i] = rand_word();
      it.b[i] = rand_word();
    end
    it.factor = rand_word();
    return it;
  endfunction

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_saturation_extremes();
    send_vec(make_vec(CmdAdd, WordMax, WordMin, WordMax, WordMax, WordMin, -1, 0), 0);
    send_vec(make_vec(CmdSub, WordMin, WordMax, 0, WordMax, WordMin, WordMin, 0), 0);
    send_vec(make_vec(CmdScale, WordMax, WordMin, WordMin, 0, 0, 0, WordMin), 0);
    send_vec(make_vec(CmdScale, WordMax, -1, 1, 0, 0, 0, WordMax), 0);
    send_vec(make_vec(CmdDot, WordMax, WordMax, WordMax, WordMax, WordMax, WordMax, 0), 0);
    send_vec(make_vec(CmdDot, WordMin, WordMin, WordMin, WordMax, WordMax, WordMax, 0), 0);
    send_vec(make_vec(CmdCross, WordMin, WordMax, WordMin, WordMax, WordMin, WordMax, 0), 0);
    send_vec(make_vec(CmdLen, WordMin, WordMin, WordMin, 0, 0, 0, 0), 0);
    send_vec(make_vec(CmdLen, WordMax, WordMax, 0, 0, 0, 0, 0), 0);
    send_vec(make_vec(CmdNorm, WordMin, WordMax, WordMin, 0, 0, 0, 0), 2);
  endtask

  task automatic test_each_command();
    send_vec(make_vec(CmdAdd, 32'h1_8000, -32'h2_0000, 5, 32'h0_8000, 7, -9, 3), 0);
    send_vec(make_vec(CmdSub, 32'h1_8000, -32'h2_0000, 5, 32'h0_8000, 7, -9, 3), 1);
    send_vec(make_vec(CmdScale, 32'h3_0000, -32'h1_0001, 7, 0, 0, 0, -32'h0_8000), 0);
    send_vec(make_vec(CmdDot, 32'h1_0000, -3, 32'h2_0000, -1, 32'h4_0000, 5, 0), 0);
    send_vec(make_vec(CmdCross, 32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 0), 0);
    send_vec(make_vec(CmdLen, 32'h3_0000, 32'h4_0000, 0, 0, 0, 0, 0), 0);
    send_vec(make_vec(CmdNorm, 32'h3_0000, -32'h4_0000, 0, 1, 2, 3, 4), 0);
    send_vec(make_vec(CmdUnknown, WordMax, 1, 2, 3, 4, 5, 6), 3);
  endtask

  task automatic test_zero_length();
    send_vec(make_vec(CmdNorm, 0, 0, 0, WordMax, WordMin, 1, WordMax), 0);
    send_vec(make_vec(CmdLen, 0, 0, 0, 1, 1, 1, 1), 0);
    send_vec(make_vec(CmdNorm, 1, 0, 0, 0, 0, 0, 0), 0);
    send_vec(make_vec(CmdNorm, -1, 0, -1, 0, 0, 0, 0), 0);
    send_vec(make_vec(CmdNorm, 0, 0, -32'h0001_0000, 0, 0, 0, 0), 1);
  endtask

  // Send a batch, hold off the sender until the pipeline has fully drained, then send more
  task automatic test_drain_pause();
    for (int n = 0; n < 12; n++) send_vec(rand_vec(), 0);
    in_valid <= 1'b0;
    wait_drained();
    @(posedge clk);
    for (int n = 0; n < 12; n++) send_vec(rand_vec(), $urandom_range(0, 1));
  endtask

  // Bursts of random length, with random gaps in between
  task automatic test_random_stream();
    int unsigned sent;
    int unsigned burst;
    int unsigned idle;
    sent = 0;
    while (sent < RandItems) begin
      burst = $urandom_range(1, 40);
      idle  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      for (int n = 0; n < burst && sent < RandItems; n++) begin
        send_vec(rand_vec(), (n == burst - 1) ? idle : 0);
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  // Receiver stalls: rotate through four ready patterns in turn
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    case ((cycle_cnt >> 6) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= cycle_cnt[2];
    endcase
  end

  // Compare every result beat with the oldest prediction
  always @(posedge clk) begin
    vec_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (rx !== want.r[0]) report_mismatch("rx", rx, want.r[0]);
        if (ry !== want.r[1]) report_mismatch("ry", ry, want.r[1]);
        if (rz !== want.r[2]) report_mismatch("rz", rz, want.r[2]);
        if (sc_out !== want.sc) report_mismatch("scalar_out", sc_out, want.sc);
        if (ov_out !== want.ov) report_mismatch("overflow", 32'(ov_out), 32'(want.ov));
      end
    end
  end

  initial begin
    err_count = 0;
    cycle_cnt = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    out_ready <= 1'b0;
    cmd       <= CmdAdd;
    ax        <= '0;
    ay        <= '0;
    az        <= '0;
    bx        <= '0;
    by_c      <= '0;
    bz        <= '0;
    factor    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_saturation_extremes();
    test_each_command();
    test_zero_length();
    test_drain_pause();
    test_random_stream();

    wait_drained();
    repeat (80) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
